/* sv/bprf_pkg.sv */
// ----------------------------------------------------------------------------
// bprf_pkg
// Shared types and constants for the batched-publish ring queue.
// ----------------------------------------------------------------------------
package bprf_pkg;

   localparam int DEPTH      = 256;
   localparam int ELEM_WIDTH = 64;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int BATCH_W    = 8;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [63:0] data_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] data_out;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
   } ctl_type;

endpackage

/* sv/bprf_ram.sv */
// ----------------------------------------------------------------------------
// bprf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bprf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bprf_ctrl.sv */
// ----------------------------------------------------------------------------
// bprf_ctrl
// Producer and consumer index state, cached-index refresh and batch publish.
// ----------------------------------------------------------------------------
module bprf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        operation,
   input  logic [bprf_pkg::BATCH_W-1:0] batch_size,
   output bprf_pkg::ctl_type           ctl
);

   localparam int IW = bprf_pkg::IDX_W;
   localparam int BW = bprf_pkg::BATCH_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(bprf_pkg::DEPTH - 1);

   logic [IW-1:0] prod_next_ff, prod_next_in;
   logic [IW-1:0] pub_write_ff, pub_write_in;
   logic [IW-1:0] prod_seen_ff, prod_seen_in;
   logic [BW-1:0] prod_batch_ff, prod_batch_in;
   logic [IW-1:0] cons_next_ff, cons_next_in;
   logic [IW-1:0] pub_read_ff, pub_read_in;
   logic [IW-1:0] cons_seen_ff, cons_seen_in;
   logic [BW-1:0] cons_batch_ff, cons_batch_in;

   logic [IW-1:0] prod_after, cons_after;
   logic [BW-1:0] prod_cnt, cons_cnt;
   logic          prod_blocked, cons_blocked, full, empty;

   always_comb begin
      prod_after   = (prod_next_ff == LAST_IDX) ? '0 : prod_next_ff + 1'b1;
      cons_after   = (cons_next_ff == LAST_IDX) ? '0 : cons_next_ff + 1'b1;
      prod_blocked = (prod_after == prod_seen_ff);
      cons_blocked = (cons_next_ff == cons_seen_ff);
      full         = prod_blocked && (prod_after == pub_read_ff);
      empty        = cons_blocked && (cons_next_ff == pub_write_ff);
      prod_cnt     = prod_batch_ff + 1'b1;
      cons_cnt     = cons_batch_ff + 1'b1;

      prod_next_in  = prod_next_ff;
      pub_write_in  = pub_write_ff;
      prod_seen_in  = prod_seen_ff;
      prod_batch_in = prod_batch_ff;
      cons_next_in  = cons_next_ff;
      pub_read_in   = pub_read_ff;
      cons_seen_in  = cons_seen_ff;
      cons_batch_in = cons_batch_ff;

      ctl.status = bprf_pkg::ST_OK;
      ctl.wr_en  = 1'b0;
      ctl.rd_en  = 1'b0;
      ctl.addr   = (operation == bprf_pkg::OP_INSERT) ? prod_next_ff : cons_next_ff;

      if (operation == bprf_pkg::OP_INSERT) begin
         if (full) begin
            ctl.status = bprf_pkg::ST_FULL;
         end else begin
            ctl.wr_en = accept;
            if (prod_blocked) begin
               prod_seen_in = pub_read_ff;
            end
            prod_next_in = prod_after;
            if (prod_cnt >= batch_size) begin
               pub_write_in  = prod_after;
               prod_batch_in = '0;
            end else begin
               prod_batch_in = prod_cnt;
            end
         end
      end else begin
         if (empty) begin
            ctl.status = bprf_pkg::ST_EMPTY;
         end else begin
            ctl.rd_en = accept;
            if (cons_blocked) begin
               cons_seen_in = pub_write_ff;
            end
            cons_next_in = cons_after;
            if (cons_cnt >= batch_size) begin
               pub_read_in   = cons_after;
               cons_batch_in = '0;
            end else begin
               cons_batch_in = cons_cnt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_next_ff  <= '0;
         pub_write_ff  <= '0;
         prod_seen_ff  <= '0;
         prod_batch_ff <= '0;
         cons_next_ff  <= '0;
         pub_read_ff   <= '0;
         cons_seen_ff  <= '0;
         cons_batch_ff <= '0;
      end else if (accept) begin
         prod_next_ff  <= prod_next_in;
         pub_write_ff  <= pub_write_in;
         prod_seen_ff  <= prod_seen_in;
         prod_batch_ff <= prod_batch_in;
         cons_next_ff  <= cons_next_in;
         pub_read_ff   <= pub_read_in;
         cons_seen_ff  <= cons_seen_in;
         cons_batch_ff <= cons_batch_in;
      end
   end

endmodule

/* sv/batched_publish_ring_fifo.sv */
// ----------------------------------------------------------------------------
// batched_publish_ring_fifo
// SPSC ring queue with batched index publication; one word in, one word out.
// ----------------------------------------------------------------------------
// The response is valid in the cycle after the request is accepted.
// Throughput: 1 word per cycle while the response side does not stall; the
// slot RAM's registered read port sets the single response stage.
// A request is taken whenever the response register is empty or being drained.
// Synchronous reset clears all indices and batch counts; batch size resets to 1.
// Slot contents are not cleared.
module batched_publish_ring_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bprf_pkg::req_type                 req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bprf_pkg::rsp_type                 rsp_payload,
   input  logic                              csr_write_enable,
   input  logic [bprf_pkg::BATCH_W-1:0]      csr_write_data
);

   localparam int EW = bprf_pkg::ELEM_WIDTH;

   logic [bprf_pkg::BATCH_W-1:0] batch_size_ff;
   logic                         rsp_valid_ff;
   logic [1:0]                   status_ff;
   logic                         rd_ok_ff;
   logic                         accept;
   bprf_pkg::ctl_type            ctl;
   logic [EW-1:0]                rd_data;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= bprf_pkg::BATCH_W'(1);
      end else if (csr_write_enable) begin
         batch_size_ff <= csr_write_data;
      end
   end

   bprf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_payload.operation),
      .batch_size (batch_size_ff),
      .ctl        (ctl)
   );

   bprf_ram #(
      .WIDTH (EW),
      .DEPTH (bprf_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ctl.wr_en),
      .wr_addr (ctl.addr),
      .wr_data (req_payload.data_in[EW-1:0]),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= ctl.status;
         rd_ok_ff  <= ctl.rd_en;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_payload.status   = status_ff;
   assign rsp_payload.data_out = rd_ok_ff ? 64'(rd_data) : 64'd0;

endmodule

/* sv/bprf_checker.sv */
// ----------------------------------------------------------------------------
// bprf_checker
// Port-level checks for the batched-publish ring queue, bound to the top.
// ----------------------------------------------------------------------------
module bprf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input bprf_pkg::req_type            req_payload,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input bprf_pkg::rsp_type            rsp_payload,
   input logic                         csr_write_enable
);

   a_one_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("response missing one cycle after accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != bprf_pkg::ST_OK |-> rsp_payload.data_out == 64'd0)
      else $error("failed operation returned data");

   a_status_matches_op: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_payload.operation == bprf_pkg::OP_INSERT
      |=> rsp_payload.status != bprf_pkg::ST_EMPTY)
      else $error("insert reported empty");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !req_valid && !rsp_valid)
      else $error("batch size written with a word in flight");

endmodule

bind batched_publish_ring_fifo bprf_checker u_bprf_checker (.*);
